### design/eti_pkg.sv
// Shared types and constants for the Ethernet frame tag inserter.
// Holds the configuration record, the queue entry layout and register index codes.
// No dependencies.
`timescale 1ns / 1ps

package eti_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DST_MAC    = 3'd0;
    localparam logic [2:0] CFG_SRC_MAC    = 3'd1;
    localparam logic [2:0] CFG_MAC_SELECT = 3'd2;
    localparam logic [2:0] CFG_TPID       = 3'd3;
    localparam logic [2:0] CFG_VLAN_ID    = 3'd4;
    localparam logic [2:0] CFG_PRIORITY   = 3'd5;
    localparam logic [2:0] CFG_RAW_BYTES  = 3'd6;
    localparam logic [2:0] CFG_RAW_LENGTH = 3'd7;

    // Frame geometry.
    localparam logic [15:0] SRC_MAC_FIRST = 16'd6;
    localparam logic [15:0] INSERT_POS    = 16'd11;
    localparam logic [15:0] MAC_LAST_END  = 16'd12;
    localparam logic [15:0] MIN_TAG_LEN   = 16'd12;
    localparam logic [15:0] MIN_EDIT_LEN  = 16'd20;

    // Priority generator seed.
    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    // Number of tag bytes.
    localparam int TAG_BYTES = 4;

    // Configuration register file contents.
    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [1:0]  mac_select;
        logic [15:0] tpid;
        logic [11:0] vlan_id;
        logic [3:0]  priority_setting;
        logic [63:0] raw_bytes;
        logic [3:0]  raw_length;
    } cfg_t;

    // One classified input byte on its way to the output sequencer.
    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        logic       insert;
        logic [2:0] pcp;
    } q_entry_t;

endpackage

### design/eti_front.sv
// Front end of the tag inserter: accepts input words and classifies each byte.
// Tracks the byte position, overwrites MAC bytes and draws the frame priority.
// Depends on eti_pkg.
`timescale 1ns / 1ps

module eti_front #(
    parameter int MAX_FRAME_BYTES = 65535
) (
    input  logic              clk,
    input  logic              rst_n,
    input  eti_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic [15:0]       frame_length,
    output logic              push,
    output eti_pkg::q_entry_t push_entry,
    input  logic              queue_full
);

    localparam logic [15:0] MAX_LEN = 16'(MAX_FRAME_BYTES);

    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    logic [15:0] lfsr_reg;
    logic [15:0] lfsr_next;

    logic [15:0] len_c;
    logic        end_c;
    logic        edit_ok;
    logic [2:0]  dst_idx;
    logic [2:0]  src_idx;
    logic [7:0]  byte_c;
    logic        insert_c;
    logic        tag_on;
    logic        random_pcp;
    logic [2:0]  pcp_c;
    logic        lfsr_fb;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    // Clamp the carried length and decide whether this byte ends the frame.
    always_comb
    begin
        len_c = frame_length;
        if (len_c > MAX_LEN)
        begin
            len_c = MAX_LEN;
        end
        if (len_c == 16'd0)
        begin
            len_c = 16'd1;
        end
        end_c = ({1'b0, pos_reg} + 17'd1) >= {1'b0, len_c};
    end

    // MAC overwrite, only in frames long enough to be edited.
    always_comb
    begin
        edit_ok = len_c >= eti_pkg::MIN_EDIT_LEN;
        dst_idx = 3'(16'd5 - pos_reg);
        src_idx = 3'(16'd11 - pos_reg);
        byte_c  = data_byte;
        if (edit_ok && pos_reg < eti_pkg::SRC_MAC_FIRST && cfg.mac_select[0])
        begin
            byte_c = cfg.dst_mac[8*dst_idx +: 8];
        end
        else if (edit_ok && pos_reg >= eti_pkg::SRC_MAC_FIRST
                 && pos_reg < eti_pkg::MAC_LAST_END && cfg.mac_select[1])
        begin
            byte_c = cfg.src_mac[8*src_idx +: 8];
        end
    end

    // Insertion point and priority for the tag.
    always_comb
    begin
        insert_c   = (pos_reg == eti_pkg::INSERT_POS) && (len_c >= eti_pkg::MIN_TAG_LEN);
        tag_on     = (cfg.tpid != 16'd0) && (cfg.vlan_id != 12'd0);
        random_pcp = cfg.priority_setting[3];
        pcp_c      = random_pcp ? lfsr_reg[2:0] : cfg.priority_setting[2:0];
        lfsr_fb    = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];
        lfsr_next  = lfsr_reg;
        if (push && insert_c && tag_on && random_pcp)
        begin
            lfsr_next = {lfsr_fb, lfsr_reg[15:1]};
        end
    end

    // Position counter returns to zero after the last byte of a frame.
    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            pos_next = end_c ? 16'd0 : pos_reg + 16'd1;
        end
    end

    always_comb
    begin
        push_entry.data      = byte_c;
        push_entry.frame_end = end_c;
        push_entry.insert    = insert_c;
        push_entry.pcp       = pcp_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 16'd0;
            lfsr_reg <= eti_pkg::LFSR_SEED;
        end
        else
        begin
            pos_reg  <= pos_next;
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

### design/eti_queue.sv
// Two-entry queue between the classifying front end and the output sequencer.
// Lets either side stall without immediately blocking the other.
// Depends on eti_pkg.
`timescale 1ns / 1ps

module eti_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  eti_pkg::q_entry_t push_entry,
    input  logic              pop,
    output eti_pkg::q_entry_t head,
    output logic              empty,
    output logic              full
);

    eti_pkg::q_entry_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign empty = count_reg == 2'd0;
    assign full  = count_reg == 2'd2;
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");
`endif

endmodule

### design/eti_back.sv
// Output sequencer of the tag inserter: turns each queued byte into its output words.
// Emits the byte itself, then raw bytes and the tag after the insertion point.
// Depends on eti_pkg.
`timescale 1ns / 1ps

module eti_back #(
    parameter int RAW_MAX_BYTES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  eti_pkg::cfg_t     cfg,
    input  eti_pkg::q_entry_t head,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              frame_last,
    output logic              run_last
);

    localparam int SUB_W = $clog2(RAW_MAX_BYTES + eti_pkg::TAG_BYTES + 2);

    logic [SUB_W-1:0] sub_reg;
    logic [SUB_W-1:0] sub_next;
    logic             valid_reg;
    logic             valid_next;
    logic [7:0]       byte_reg;
    logic             flast_reg;
    logic             rlast_reg;

    logic [SUB_W-1:0] rl_sat;
    logic [SUB_W-1:0] extra;
    logic [SUB_W-1:0] sub_m1;
    logic             tag_on;
    logic             is_last;
    logic             load;
    logic [2:0]       raw_idx;
    logic [1:0]       tag_idx;
    logic [7:0]       byte_c;

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign frame_last = flast_reg;
    assign run_last   = rlast_reg;

    // Number of words that follow the byte itself.
    always_comb
    begin
        rl_sat = (cfg.raw_length > 4'(RAW_MAX_BYTES)) ? SUB_W'(RAW_MAX_BYTES)
                                                        : SUB_W'(cfg.raw_length);
        tag_on = (cfg.tpid != 16'd0) && (cfg.vlan_id != 12'd0);
        extra  = '0;
        if (head.insert)
        begin
            extra = rl_sat + (tag_on ? SUB_W'(eti_pkg::TAG_BYTES) : SUB_W'(0));
        end
        is_last = sub_reg == extra;
        load    = !empty && (!valid_reg || out_ready);
        pop     = load && is_last;
    end

    // Select the byte for the current step.
    always_comb
    begin
        sub_m1  = sub_reg - SUB_W'(1);
        raw_idx = 3'(rl_sat - sub_reg);
        tag_idx = 2'(sub_m1 - rl_sat);
        byte_c  = head.data;
        if (sub_reg != '0)
        begin
            if (sub_m1 < rl_sat)
            begin
                byte_c = cfg.raw_bytes[8*raw_idx +: 8];
            end
            else
            begin
                case (tag_idx)
                    2'd0:    byte_c = cfg.tpid[15:8];
                    2'd1:    byte_c = cfg.tpid[7:0];
                    2'd2:    byte_c = {head.pcp, 1'b0, cfg.vlan_id[11:8]};
                    2'd3:    byte_c = cfg.vlan_id[7:0];
                    default: byte_c = cfg.vlan_id[7:0];
                endcase
            end
        end
    end

    // Step counter and output word valid.
    always_comb
    begin
        sub_next   = sub_reg;
        valid_next = valid_reg;
        if (load)
        begin
            sub_next   = is_last ? '0 : sub_reg + SUB_W'(1);
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= byte_c;
            flast_reg <= head.frame_end && is_last;
            rlast_reg <= is_last;
        end
    end

`ifndef SYNTHESIS
    a_flast_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && flast_reg |-> rlast_reg)
        else $error("frame end word is not the last word of its run");
    a_sub_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> sub_reg <= extra)
        else $error("step counter ran past the end of its run");
`endif

endmodule

### design/ethernet_frame_tag_inserter.sv
// Top level of the Ethernet frame tag inserter.
// Holds the configuration registers and joins front end, queue and output sequencer.
// Depends on eti_pkg, eti_front, eti_queue and eti_back.
`timescale 1ns / 1ps

// Usage:
// Input bytes arrive on the s_axis channel, each with the length of its frame.
// Edited bytes leave on the m_axis channel; tlast marks the last byte of an
// edited frame and tuser the last word produced by one input byte.
// Configuration registers are written through the cfg channel, which is always
// ready; write only while the block holds no undelivered word.
// An accepted input byte is registered in a queue slot, then in the output register.
// Throughput is one byte per cycle while m_axis_tready is high. Byte 11 of a frame
// of twelve or more bytes produces 1 + raw_length (at most eight) + 4 (with tag)
// words, one per cycle through the output register while m_axis_tready is high; the
// next byte enters the two-entry queue and the input stalls until that run ends.
// A stalled receiver holds the output word; the queue absorbs up to two more
// input bytes (one while bytes stream back to back) before s_axis_tready drops.
// Reset clears the byte position, the queue and the output valid flag, loads the
// priority generator with its seed and clears all configuration registers.
module ethernet_frame_tag_inserter #(
    parameter int RAW_MAX_BYTES   = 8,
    parameter int MAX_FRAME_BYTES = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] frame_length
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // frame_last
    output logic [0:0]  m_axis_tuser,   // [0] run_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    eti_pkg::cfg_t     cfg_reg;
    eti_pkg::cfg_t     cfg_next;
    eti_pkg::q_entry_t push_entry;
    eti_pkg::q_entry_t head;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    logic              run_last;

    assign cfg_ready       = 1'b1;
    assign m_axis_tuser[0] = run_last;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                eti_pkg::CFG_DST_MAC:    cfg_next.dst_mac          = cfg_data[47:0];
                eti_pkg::CFG_SRC_MAC:    cfg_next.src_mac          = cfg_data[47:0];
                eti_pkg::CFG_MAC_SELECT: cfg_next.mac_select       = cfg_data[1:0];
                eti_pkg::CFG_TPID:       cfg_next.tpid             = cfg_data[15:0];
                eti_pkg::CFG_VLAN_ID:    cfg_next.vlan_id          = cfg_data[11:0];
                eti_pkg::CFG_PRIORITY:   cfg_next.priority_setting = cfg_data[3:0];
                eti_pkg::CFG_RAW_BYTES:  cfg_next.raw_bytes        = cfg_data;
                eti_pkg::CFG_RAW_LENGTH: cfg_next.raw_length       = cfg_data[3:0];
                default:                 cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Classifying front end.
    eti_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .data_byte    (s_axis_tdata[7:0]),
        .frame_length (s_axis_tdata[23:8]),
        .push         (push),
        .push_entry   (push_entry),
        .queue_full   (q_full)
    );

    // Decoupling queue.
    eti_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // Output sequencer.
    eti_back #(
        .RAW_MAX_BYTES(RAW_MAX_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .empty      (q_empty),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .frame_last (m_axis_tlast),
        .run_last   (run_last)
    );

endmodule
